@@ rtl/cda_pkg.sv @@
// ----------------------------------------------------------------------------
// cda_pkg - shared types and constants for the calendar date adder
// Field codes, operation codes, control/status bundles and month length.
// ----------------------------------------------------------------------------
package cda_pkg;

   // working width of the lower five fields (holds any value before wrap)
   localparam int FW = 12;
   // width of the shared adder (year plus a signed amount)
   localparam int AW = 16;
   // year width and its saturation limit
   localparam int YW = 14;
   localparam logic [YW-1:0] YEAR_MAX = 14'd16383;

   // reset date
   localparam logic [YW-1:0] YEAR_RESET = 14'd1900;

   // field limits
   localparam logic [5:0] SEC_MAX  = 6'd59;
   localparam logic [5:0] MIN_MAX  = 6'd59;
   localparam logic [4:0] HOUR_MAX = 5'd23;
   localparam logic [3:0] MON_MAX  = 4'd12;
   localparam logic [3:0] MON_FEB  = 4'd2;

   // spans added or removed by one wrap
   localparam logic [5:0] SEC_SPAN  = 6'd60;
   localparam logic [5:0] MIN_SPAN  = 6'd60;
   localparam logic [5:0] HOUR_SPAN = 6'd24;
   localparam logic [5:0] MON_SPAN  = 6'd12;

   // item kinds carried on req_tuser
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_ADD  = 2'd1;
   localparam logic [1:0] ACT_SUB  = 2'd2;

   // field selector, lowest field first
   typedef enum logic [2:0] {
      FLD_SEC  = 3'd0,
      FLD_MIN  = 3'd1,
      FLD_HOUR = 3'd2,
      FLD_DAY  = 3'd3,
      FLD_MON  = 3'd4,
      FLD_YEAR = 3'd5
   } fld_type;

   // operations of the shared adder
   typedef enum logic [2:0] {
      OP_AMT  = 3'd0,   // add or subtract the item amount
      OP_INC  = 3'd1,   // carry in
      OP_DEC  = 3'd2,   // borrow in
      OP_WRAP = 3'd3,   // remove one field span
      OP_FIX  = 3'd4    // restore one field span after a borrow
   } alu_op_type;

   // sequencer to datapath
   typedef struct packed {
      logic       capture;
      logic       load;
      logic       alu_en;
      logic       sub;
      alu_op_type op;
      fld_type    fld;
   } dp_ctl_type;

   // datapath to sequencer
   typedef struct packed {
      logic amt_zero;
      logic over;
      logic under;
   } dp_stat_type;

   // date as delivered, second in the lowest bits
   typedef struct packed {
      logic [YW-1:0] year;
      logic [3:0]    month;
      logic [4:0]    day;
      logic [4:0]    hour;
      logic [5:0]    minute;
      logic [5:0]    second;
   } date_type;

   // days in a month; every fourth year is a leap year
   function automatic logic [4:0] month_len(input logic [3:0] month,
                                            input logic [1:0] year_lo);
      logic [4:0] len;
      if (month inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
         len = 5'd31;
      end else if (month == MON_FEB) begin
         len = (year_lo == 2'b00) ? 5'd29 : 5'd28;
      end else begin
         len = 5'd30;
      end
      return len;
   endfunction

endpackage

@@ rtl/cda_datapath.sv @@
// ----------------------------------------------------------------------------
// cda_datapath - date registers and the shared field adder
// Holds the six date fields and the captured amounts, applies one adder
// operation per cycle, when enabled, to the selected field and reports its range status.
// ----------------------------------------------------------------------------
module cda_datapath
   import cda_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dp_ctl_type        ctl,
   input  logic [9:0]        second_val,
   input  logic [9:0]        minute_val,
   input  logic [9:0]        hour_val,
   input  logic [9:0]        day_val,
   input  logic [9:0]        month_val,
   input  logic [YW-1:0]     year_val,
   output dp_stat_type       stat,
   output date_type          date
);

   logic signed [FW-1:0] sec_ff, sec_in;
   logic signed [FW-1:0] min_ff, min_in;
   logic signed [FW-1:0] hour_ff, hour_in;
   logic signed [FW-1:0] day_ff, day_in;
   logic signed [FW-1:0] mon_ff, mon_in;
   logic [YW-1:0]        year_ff, year_in;
   logic [YW-1:0]        amt_ff [6];

   logic signed [AW-1:0] cur;
   logic signed [AW-1:0] operand;
   logic signed [AW-1:0] sum;
   logic [YW-1:0]        amt_sel;
   logic [YW-1:0]        year_sat;
   logic [5:0]           span;
   logic [5:0]           fmax;
   logic                 fmin;
   logic [4:0]           cur_len;

   logic [5:0]           sec_ld;
   logic [5:0]           min_ld;
   logic [4:0]           hour_ld;
   logic [3:0]           mon_ld;
   logic [4:0]           len_ld;
   logic [4:0]           day_ld;

   // month length for the day field as the date stands now
   assign cur_len = month_len(mon_ff[3:0], year_ff[1:0]);

   // select the field, its limits and its amount
   always_comb begin
      cur     = '0;
      span    = '0;
      fmax    = '0;
      fmin    = 1'b0;
      amt_sel = '0;
      case (ctl.fld)
         FLD_SEC: begin
            cur     = AW'(sec_ff);
            span    = SEC_SPAN;
            fmax    = SEC_MAX;
            amt_sel = amt_ff[0];
         end
         FLD_MIN: begin
            cur     = AW'(min_ff);
            span    = MIN_SPAN;
            fmax    = MIN_MAX;
            amt_sel = amt_ff[1];
         end
         FLD_HOUR: begin
            cur     = AW'(hour_ff);
            span    = HOUR_SPAN;
            fmax    = 6'(HOUR_MAX);
            amt_sel = amt_ff[2];
         end
         FLD_DAY: begin
            cur     = AW'(day_ff);
            span    = 6'(cur_len);
            fmax    = 6'(cur_len);
            fmin    = 1'b1;
            amt_sel = amt_ff[3];
         end
         FLD_MON: begin
            cur     = AW'(mon_ff);
            span    = MON_SPAN;
            fmax    = 6'(MON_MAX);
            fmin    = 1'b1;
            amt_sel = amt_ff[4];
         end
         FLD_YEAR: begin
            cur     = $signed({{(AW-YW){1'b0}}, year_ff});
            amt_sel = amt_ff[5];
         end
         default: begin
            cur = '0;
         end
      endcase
   end

   // range status of the selected field; the year never leaves its range
   always_comb begin
      stat.amt_zero = (amt_sel == '0);
      stat.over     = (ctl.fld != FLD_YEAR) &&
                      (cur > $signed({{(AW-6){1'b0}}, fmax}));
      stat.under    = (ctl.fld != FLD_YEAR) &&
                      (cur < $signed({{(AW-1){1'b0}}, fmin}));
   end

   // shared adder
   always_comb begin
      case (ctl.op)
         OP_AMT:  operand = ctl.sub ? -$signed({{(AW-YW){1'b0}}, amt_sel})
                                    :  $signed({{(AW-YW){1'b0}}, amt_sel});
         OP_INC:  operand = AW'(1);
         OP_DEC:  operand = -AW'(1);
         OP_WRAP: operand = -$signed({{(AW-6){1'b0}}, span});
         OP_FIX:  operand =  $signed({{(AW-6){1'b0}}, span});
         default: operand = '0;
      endcase
      sum = cur + operand;
   end

   // saturate the year at both ends
   always_comb begin
      if (sum < 0) begin
         year_sat = '0;
      end else if (sum > $signed({{(AW-YW){1'b0}}, YEAR_MAX})) begin
         year_sat = YEAR_MAX;
      end else begin
         year_sat = sum[YW-1:0];
      end
   end

   // clamp the captured load date into its legal ranges
   always_comb begin
      sec_ld  = (amt_ff[0] > YW'(SEC_MAX)) ? SEC_MAX : amt_ff[0][5:0];
      min_ld  = (amt_ff[1] > YW'(MIN_MAX)) ? MIN_MAX : amt_ff[1][5:0];
      hour_ld = (amt_ff[2] > YW'(HOUR_MAX)) ? HOUR_MAX : amt_ff[2][4:0];
      if (amt_ff[4] == '0) begin
         mon_ld = 4'd1;
      end else if (amt_ff[4] > YW'(MON_MAX)) begin
         mon_ld = MON_MAX;
      end else begin
         mon_ld = amt_ff[4][3:0];
      end
      len_ld = month_len(mon_ld, amt_ff[5][1:0]);
      if (amt_ff[3] == '0) begin
         day_ld = 5'd1;
      end else if (amt_ff[3] > YW'(len_ld)) begin
         day_ld = len_ld;
      end else begin
         day_ld = amt_ff[3][4:0];
      end
   end

   // next field values
   always_comb begin
      sec_in  = sec_ff;
      min_in  = min_ff;
      hour_in = hour_ff;
      day_in  = day_ff;
      mon_in  = mon_ff;
      year_in = year_ff;
      if (ctl.load) begin
         sec_in  = FW'(sec_ld);
         min_in  = FW'(min_ld);
         hour_in = FW'(hour_ld);
         day_in  = FW'(day_ld);
         mon_in  = FW'(mon_ld);
         year_in = amt_ff[5];
      end else if (ctl.alu_en) begin
         case (ctl.fld)
            FLD_SEC:  sec_in  = sum[FW-1:0];
            FLD_MIN:  min_in  = sum[FW-1:0];
            FLD_HOUR: hour_in = sum[FW-1:0];
            FLD_DAY:  day_in  = sum[FW-1:0];
            FLD_MON:  mon_in  = sum[FW-1:0];
            FLD_YEAR: year_in = year_sat;
            default:  sec_in  = sec_ff;
         endcase
      end
   end

   // date registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff  <= '0;
         min_ff  <= '0;
         hour_ff <= '0;
         day_ff  <= FW'(1);
         mon_ff  <= FW'(1);
         year_ff <= YEAR_RESET;
      end else begin
         sec_ff  <= sec_in;
         min_ff  <= min_in;
         hour_ff <= hour_in;
         day_ff  <= day_in;
         mon_ff  <= mon_in;
         year_ff <= year_in;
      end
   end

   // capture the amounts of an accepted word
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         amt_ff[0] <= YW'(second_val);
         amt_ff[1] <= YW'(minute_val);
         amt_ff[2] <= YW'(hour_val);
         amt_ff[3] <= YW'(day_val);
         amt_ff[4] <= YW'(month_val);
         amt_ff[5] <= year_val;
      end
   end

   assign date.second = sec_ff[5:0];
   assign date.minute = min_ff[5:0];
   assign date.hour   = hour_ff[4:0];
   assign date.day    = day_ff[4:0];
   assign date.month  = mon_ff[3:0];
   assign date.year   = year_ff;

endmodule

@@ rtl/cda_ctrl.sv @@
// ----------------------------------------------------------------------------
// cda_ctrl - sequencer for the calendar date adder
// Loads a date, or walks the fields from seconds to years, applies each amount and resolves
// every wrap with its carry or borrow, at most one adder step per cycle.
// ----------------------------------------------------------------------------
module cda_ctrl
   import cda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  action,
   input  dp_stat_type stat,
   input  logic        out_free,
   output dp_ctl_type  ctl,
   output logic        finish
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_LOAD  = 6'b000010,
      S_APPLY = 6'b000100,
      S_CHECK = 6'b001000,
      S_CARRY = 6'b010000,
      S_FIX   = 6'b100000
   } state_type;

   // the done step reuses the idle-free wait below
   state_type state_ff, state_in;
   fld_type   base_ff, base_in;
   fld_type   ptr_ff, ptr_in;
   logic      sub_ff, sub_in;
   logic      done_ff, done_in;
   logic      out_rng;

   assign out_rng = sub_ff ? stat.under : stat.over;

   // next state and control for the datapath
   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      ptr_in      = ptr_ff;
      sub_in      = sub_ff;
      done_in     = done_ff;
      req_tready  = 1'b0;
      finish      = 1'b0;
      ctl.capture = 1'b0;
      ctl.load    = 1'b0;
      ctl.alu_en  = 1'b0;
      ctl.sub     = sub_ff;
      ctl.op      = OP_AMT;
      ctl.fld     = ptr_ff;
      case (state_ff)
         S_IDLE: begin
            if (done_ff) begin
               // hold the result until the output register is free
               if (out_free) begin
                  finish  = 1'b1;
                  done_in = 1'b0;
               end
            end else begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  ctl.capture = 1'b1;
                  sub_in      = (action == ACT_SUB);
                  base_in     = FLD_SEC;
                  ptr_in      = FLD_SEC;
                  case (action)
                     ACT_LOAD: state_in = S_LOAD;
                     ACT_ADD:  state_in = S_APPLY;
                     ACT_SUB:  state_in = S_APPLY;
                     default:  done_in  = 1'b1;
                  endcase
               end
            end
         end
         S_LOAD: begin
            ctl.load = 1'b1;
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         S_APPLY: begin
            // apply the amount of the base field; skip a zero amount
            ctl.fld = base_ff;
            ptr_in  = base_ff;
            if (!stat.amt_zero) begin
               ctl.alu_en = 1'b1;
               ctl.op     = OP_AMT;
            end
            if (base_ff == FLD_YEAR) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else if (stat.amt_zero) begin
               base_in = fld_type'(base_ff + 3'd1);
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (out_rng) begin
               // wrap now on add; on subtract borrow first, restore later
               ptr_in   = fld_type'(ptr_ff + 3'd1);
               state_in = S_CARRY;
               if (!sub_ff) begin
                  ctl.alu_en = 1'b1;
                  ctl.op     = OP_WRAP;
               end
            end else if (ptr_ff == base_ff) begin
               base_in  = fld_type'(base_ff + 3'd1);
               state_in = S_APPLY;
            end else begin
               // return to the field that carried or borrowed
               ptr_in   = fld_type'(ptr_ff - 3'd1);
               state_in = sub_ff ? S_FIX : S_CHECK;
            end
         end
         S_CARRY: begin
            ctl.alu_en = 1'b1;
            ctl.op     = sub_ff ? OP_DEC : OP_INC;
            state_in   = S_CHECK;
         end
         S_FIX: begin
            ctl.alu_en = 1'b1;
            ctl.op     = OP_FIX;
            state_in   = S_CHECK;
         end
         default: begin
            state_in = S_IDLE;
            done_in  = 1'b0;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff  <= FLD_SEC;
         ptr_ff   <= FLD_SEC;
         sub_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         ptr_ff   <= ptr_in;
         sub_ff   <= sub_in;
         done_ff  <= done_in;
      end
   end

`ifndef SYNTHESIS
   // carry chain only climbs above the field being applied
   a_ptr_above_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK || state_ff == S_CARRY || state_ff == S_FIX)
      |-> (ptr_ff >= base_ff))
      else $error("carry pointer below base field");

   // nothing carries into the seconds
   a_no_carry_sec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CARRY) |-> (ptr_ff != FLD_SEC))
      else $error("carry into seconds");

   // the year is saturated, so its check never asks for a wrap
   a_year_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && ptr_ff == FLD_YEAR) |-> !(stat.over || stat.under))
      else $error("year out of range");

   // an accepted word always leaves work or a pending result behind
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE || done_ff))
      else $error("accepted word dropped");
`endif

endmodule

@@ rtl/calendar_date_adder_core.sv @@
// ----------------------------------------------------------------------------
// calendar_date_adder_core - calendar date and time register with add/sub
// Loads, advances or rewinds a date and time and returns it for every word.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_*: one word per operation. req_tuser selects load,
//   add or subtract (code 3 leaves the date as is); req_tdata carries the
//   six amounts. Response channel rsp_*: one word per request, the date
//   after the operation.
//   Add and subtract work field by field, and every wrap on add and every
//   borrow on subtract costs further adder passes, since each carry,
//   borrow and span correction is one pass through the single shared
//   field adder. One request is in work at a time and req_tready is low
//   while it is. The response sits in an output register: a stalled
//   receiver holds it, and the next request is still taken and worked on,
//   finishing only once the register is free.
//   Reset (synchronous, active high) sets 1900-01-01 00:00:00 and empties
//   the response register.
// ----------------------------------------------------------------------------
module calendar_date_adder_core
   import cda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // second_val[9:0], minute_val[19:10], hour_val[29:20], day_val[39:30],
   // month_val[49:40], year_val[63:50]
   input  logic [63:0] req_tdata,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_second[5:0], out_minute[11:6], out_hour[16:12], out_day[21:17],
   // out_month[25:22], out_year[39:26]
   output logic [39:0] rsp_tdata
);

   dp_ctl_type  ctl;
   dp_stat_type stat;
   date_type    date;
   date_type    rsp_data_ff;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic        finish;
   logic        out_free;

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   cda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tuser),
      .stat       (stat),
      .out_free   (out_free),
      .ctl        (ctl),
      .finish     (finish)
   );

   cda_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .second_val (req_tdata[9:0]),
      .minute_val (req_tdata[19:10]),
      .hour_val   (req_tdata[29:20]),
      .day_val    (req_tdata[39:30]),
      .month_val  (req_tdata[49:40]),
      .year_val   (req_tdata[63:50]),
      .stat       (stat),
      .date       (date)
   );

   // response valid: set on finish, drop once taken
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (finish) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= date;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ verif/tb_calendar_date_adder_core.sv @@
// ----------------------------------------------------------------------------
// tb_calendar_date_adder_core - self-checking bench for the date adder core
// Loads, advances and rewinds the held date through the request stream and
// compares every returned date with a software copy of the calendar.
// Requests come in bursts with random gaps, and the receiver stalls on a
// changing pattern.
// ----------------------------------------------------------------------------
module tb_calendar_date_adder_core;
   import cda_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 11;
   localparam int RANDOM_WORDS   = 930;
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int TAIL_CYCLES    = 20;

   // operation code with no effect on the date
   localparam logic [1:0] ACT_KEEP = 2'd3;

   // request payload, second amount in the lowest bits
   typedef struct packed {
      logic [13:0] year_val;
      logic [9:0]  month_val;
      logic [9:0]  day_val;
      logic [9:0]  hour_val;
      logic [9:0]  minute_val;
      logic [9:0]  second_val;
   } date_req_type;

   // receiver stall patterns
   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_QUARTER,
      RX_TRICKLE
   } rx_mode_type;

   // -------------------------------------------------------------------------
   // Calendar tracker: holds the date, predicts each result, checks responses
   // -------------------------------------------------------------------------
   class date_tracker;
      int       cal[6];
      date_type expected_dates[$];
      int       errors;
      int       n_load;
      int       n_add;
      int       n_sub;
      int       n_keep;
      int       n_checked;

      function new();
         cal[FLD_SEC]  = 0;
         cal[FLD_MIN]  = 0;
         cal[FLD_HOUR] = 0;
         cal[FLD_DAY]  = 1;
         cal[FLD_MON]  = 1;
         cal[FLD_YEAR] = YEAR_RESET;
         errors    = 0;
         n_load    = 0;
         n_add     = 0;
         n_sub     = 0;
         n_keep    = 0;
         n_checked = 0;
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction

      function int days_in_month(int month, int year);
         case (month)
            1, 3, 5, 7, 8, 10, 12: return 31;
            MON_FEB:               return (year % 4 == 0) ? 29 : 28;
            default:               return 30;
         endcase
      endfunction

      // upper bound of a field, day length taken from the month held now
      function int field_top(int k);
         if (k == FLD_SEC) return SEC_MAX;
         if (k == FLD_MIN) return MIN_MAX;
         if (k == FLD_HOUR) return HOUR_MAX;
         if (k == FLD_DAY) return days_in_month(cal[FLD_MON], cal[FLD_YEAR]);
         return MON_MAX;
      endfunction

      function int field_floor(int k);
         return (k >= FLD_DAY) ? 1 : 0;
      endfunction

      function int clamp_to(int v, int lo, int hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      // add to one field, carrying one unit upward per wrap
      function void advance_field(int k, int amt);
         if (amt <= 0) return;
         if (k == FLD_YEAR) begin
            cal[FLD_YEAR] += amt;
            if (cal[FLD_YEAR] > YEAR_MAX) cal[FLD_YEAR] = YEAR_MAX;
            return;
         end
         cal[k] += amt;
         while (cal[k] > field_top(k)) begin
            cal[k] = cal[k] - field_top(k) + field_floor(k) - 1;
            advance_field(k + 1, 1);
         end
      endfunction

      // subtract from one field; borrow first, then refill with the new span
      function void rewind_field(int k, int amt);
         if (amt <= 0) return;
         if (k == FLD_YEAR) begin
            cal[FLD_YEAR] -= amt;
            if (cal[FLD_YEAR] < 0) cal[FLD_YEAR] = 0;
            return;
         end
         cal[k] -= amt;
         while (cal[k] < field_floor(k)) begin
            rewind_field(k + 1, 1);
            cal[k] += field_top(k) + 1 - field_floor(k);
         end
      endfunction

      // apply one accepted request and queue the date it should return
      function void note_request(logic [1:0] act, date_req_type w);
         int       amt[6];
         int       k;
         date_type d;
         amt[FLD_SEC]  = w.second_val;
         amt[FLD_MIN]  = w.minute_val;
         amt[FLD_HOUR] = w.hour_val;
         amt[FLD_DAY]  = w.day_val;
         amt[FLD_MON]  = w.month_val;
         amt[FLD_YEAR] = w.year_val;
         case (act)
            ACT_LOAD: begin
               n_load++;
               cal[FLD_SEC]  = clamp_to(amt[FLD_SEC], 0, SEC_MAX);
               cal[FLD_MIN]  = clamp_to(amt[FLD_MIN], 0, MIN_MAX);
               cal[FLD_HOUR] = clamp_to(amt[FLD_HOUR], 0, HOUR_MAX);
               cal[FLD_MON]  = clamp_to(amt[FLD_MON], 1, MON_MAX);
               cal[FLD_YEAR] = clamp_to(amt[FLD_YEAR], 0, YEAR_MAX);
               cal[FLD_DAY]  = clamp_to(amt[FLD_DAY], 1,
                                        days_in_month(cal[FLD_MON], cal[FLD_YEAR]));
            end
            ACT_ADD: begin
               n_add++;
               for (k = FLD_SEC; k <= FLD_YEAR; k++) advance_field(k, amt[k]);
            end
            ACT_SUB: begin
               n_sub++;
               for (k = FLD_SEC; k <= FLD_YEAR; k++) rewind_field(k, amt[k]);
            end
            default: begin
               n_keep++;
            end
         endcase
         d.second = 6'(cal[FLD_SEC]);
         d.minute = 6'(cal[FLD_MIN]);
         d.hour   = 5'(cal[FLD_HOUR]);
         d.day    = 5'(cal[FLD_DAY]);
         d.month  = 4'(cal[FLD_MON]);
         d.year   = 14'(cal[FLD_YEAR]);
         expected_dates.push_back(d);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      // compare a returned date with the oldest prediction
      task check_date(date_type got);
         date_type want;
         if (expected_dates.size() == 0) begin
            report_mismatch("unexpected response, year", got.year, -1);
            return;
         end
         want = expected_dates.pop_front();
         n_checked++;
         if (got.second != want.second) report_mismatch("second", got.second, want.second);
         if (got.minute != want.minute) report_mismatch("minute", got.minute, want.minute);
         if (got.hour != want.hour) report_mismatch("hour", got.hour, want.hour);
         if (got.day != want.day) report_mismatch("day", got.day, want.day);
         if (got.month != want.month) report_mismatch("month", got.month, want.month);
         if (got.year != want.year) report_mismatch("year", got.year, want.year);
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = ACT_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   date_tracker dates = new();
   int          idle_cycles = 0;
   int          rx_cycle = 0;
   rx_mode_type rx_mode = RX_OPEN;

   calendar_date_adder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // receiver: drive rsp_tready from a stall pattern that is picked anew at random
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_mode = rx_mode_type'($urandom_range(RX_OPEN, RX_TRICKLE));
      case (rx_mode)
         RX_OPEN:    rsp_tready = 1'b1;
         RX_COIN:    rsp_tready = 1'($urandom_range(0, 1));
         RX_QUARTER: rsp_tready = (rx_cycle % 4 == 0);
         default:    rsp_tready = (rx_cycle % 23 == 0);
      endcase
   end

   // check every accepted response word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) dates.check_date(date_type'(rsp_tdata));
   end

   // watchdog: give up after a long stretch with no handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("FAILURE");
         $finish;
      end
   end

   function automatic date_req_type mk(int s, int m, int h, int d, int mo, int y);
      date_req_type w;
      w.second_val = 10'(s);
      w.minute_val = 10'(m);
      w.hour_val   = 10'(h);
      w.day_val    = 10'(d);
      w.month_val  = 10'(mo);
      w.year_val   = 14'(y);
      return w;
   endfunction

   // present one word at the falling edge and hold it until accepted
   task automatic send_word(input logic [1:0] act, input date_req_type w);
      req_tuser  = act;
      req_tdata  = w;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      dates.note_request(act, w);
      @(negedge clock);
   endtask

   // hold off the sender until every pending date has come back
   task automatic drain_dates();
      req_tvalid = 1'b0;
      while (dates.pending() != 0) @(negedge clock);
   endtask

   // mostly zero or modest amounts, sometimes anything the field holds
   function automatic int pick_amount();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return 0;
      if (r < 8) return $urandom_range(1, 70);
      return $urandom_range(0, 1023);
   endfunction

   function automatic int pick_years();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return 0;
      if (r < 9) return $urandom_range(1, 30);
      return $urandom_range(0, 16383);
   endfunction

   // mostly legal load values, some out of range to hit the clamps
   function automatic int pick_load(int hi);
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, hi);
   endfunction

   task automatic send_random();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         send_word(ACT_LOAD, mk(pick_load(59), pick_load(59), pick_load(23),
                                pick_load(31), pick_load(12), $urandom_range(0, 16383)));
      end else if (r < 55) begin
         send_word(ACT_ADD, mk(pick_amount(), pick_amount(), pick_amount(),
                               pick_amount(), pick_amount(), pick_years()));
      end else if (r < 95) begin
         send_word(ACT_SUB, mk(pick_amount(), pick_amount(), pick_amount(),
                               pick_amount(), pick_amount(), pick_years()));
      end else begin
         send_word(ACT_KEEP, mk($urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 1023), $urandom_range(0, 16383)));
      end
   endtask

   initial begin
      int sent;
      int burst;
      int gap;
      int i;
      bit paused;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all-zero load clamps day and month up; borrow below year zero
      send_word(ACT_LOAD, mk(0, 0, 0, 0, 0, 0));
      send_word(ACT_SUB, mk(1, 0, 0, 0, 0, 0));
      // all-ones load clamps the lower five fields down; carry past the top year
      send_word(ACT_LOAD, mk(1023, 1023, 1023, 1023, 1023, 16383));
      send_word(ACT_ADD, mk(1, 0, 0, 0, 0, 0));
      // day clamp in leap and common February, then roll into March
      send_word(ACT_LOAD, mk(30, 30, 12, 31, 2, 2024));
      send_word(ACT_LOAD, mk(0, 0, 0, 30, 2, 2023));
      send_word(ACT_ADD, mk(0, 0, 0, 1, 0, 0));
      // month step leaves day 31 in a short month; next day carry uses it
      send_word(ACT_LOAD, mk(0, 0, 0, 31, 1, 2023));
      send_word(ACT_ADD, mk(0, 0, 0, 0, 1, 0));
      send_word(ACT_ADD, mk(0, 0, 0, 1, 0, 0));
      send_word(ACT_LOAD, mk(5, 6, 7, 31, 3, 2021));
      send_word(ACT_SUB, mk(0, 0, 0, 0, 1, 0));
      // zero amounts leave the out-of-range day alone; one day back steps it down
      send_word(ACT_ADD, mk(0, 0, 0, 0, 0, 0));
      send_word(ACT_SUB, mk(0, 0, 0, 0, 0, 0));
      send_word(ACT_SUB, mk(0, 0, 0, 1, 0, 0));
      // unused code keeps the date
      send_word(ACT_KEEP, mk(1023, 1023, 1023, 1023, 1023, 16383));
      // largest amounts in both directions, year saturating each way
      send_word(ACT_LOAD, mk(59, 59, 23, 31, 12, 100));
      send_word(ACT_ADD, mk(1023, 1023, 1023, 1023, 1023, 0));
      send_word(ACT_SUB, mk(1023, 1023, 1023, 1023, 1023, 0));
      send_word(ACT_ADD, mk(0, 0, 0, 0, 0, 16383));
      send_word(ACT_SUB, mk(0, 0, 0, 0, 0, 16383));
      send_word(ACT_ADD, mk(1023, 1023, 1023, 1023, 1023, 16383));
      send_word(ACT_SUB, mk(1023, 1023, 1023, 1023, 1023, 16383));
      drain_dates();

      // random bursts; pause once midway until everything is back
      sent   = 0;
      paused = 1'b0;
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, 12);
         for (i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
            send_random();
            sent++;
         end
         if (!paused && sent >= RANDOM_WORDS / 2) begin
            drain_dates();
            paused = 1'b1;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      drain_dates();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d loads, %0d adds, %0d subtracts, %0d no-op words",
               dates.n_load, dates.n_add, dates.n_sub, dates.n_keep);
      $display("%0d dates compared, %0d mismatches, %0d still outstanding",
               dates.n_checked, dates.errors, dates.pending());
      if (dates.errors == 0 && dates.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/cda_pkg.sv
rtl/cda_datapath.sv
rtl/cda_ctrl.sv
rtl/calendar_date_adder_core.sv
verif/tb_calendar_date_adder_core.sv
